>>> src/crbet_pkg.sv
// Shared types and constants for the line-camera row binarizer and edge tracker.
// Used by the controller, the datapath and the top level. No dependencies.
package crbet_pkg;

  // Row geometry.
  localparam int ROW_WIDTH = 80;
  localparam int ROWS      = 60;

  // Derived widths.
  localparam int COL_W     = $clog2(ROW_WIDTH);
  localparam int PIX_CNT_W = $clog2(ROW_WIDTH + 1);
  localparam int STEP_W    = $clog2(ROW_WIDTH + 2);
  localparam int LINE_W    = 8;
  localparam int ROW_W     = 6;
  localparam int EDGE_W    = 7;
  localparam int PIX_W     = 8;

  localparam logic [LINE_W-1:0] LINE_MAX  = '1;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ROWS * 4 - 1);

  // Line phase within a group of four syncs.
  localparam logic [1:0] PH_CAPTURE  = 2'd1;
  localparam logic [1:0] PH_BINARIZE = 2'd2;
  localparam logic [1:0] PH_SEARCH   = 2'd3;

  // Configuration register reset values.
  localparam logic [PIX_W-1:0]  LEVEL_RST  = 8'd128;
  localparam logic [EDGE_W-1:0] CENTER_RST = 7'd40;

  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_SYNC  = 2'd1,
    FUNC_PIXEL = 2'd2
  } func_e;

  typedef enum logic {
    REG_BINARY_LEVEL = 1'b0,
    REG_FIRST_CENTER = 1'b1
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic bin_start;
    logic bin_step;
    logic find_start;
    logic rd_left;
    logic left_step;
    logic left_done;
    logic rd_right;
    logic right_step;
    logic right_done;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync_bin;
    logic sync_find;
    logic bin_last;
    logic at_left_end;
    logic at_right_end;
    logic bin_bit;
    logic out_free;
  } status_t;

endpackage

>>> src/crbet_ctrl.sv
// Sequencing controller for the row binarizer and edge tracker.
// Depends on crbet_pkg for the command and status structs.
module crbet_ctrl import crbet_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_BIN  = 7'b0000010,
    S_LREQ = 7'b0000100,
    S_LCHK = 7'b0001000,
    S_RREQ = 7'b0010000,
    S_RCHK = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.sync_bin) begin
          cmd_o.bin_start = 1'b1;
          state_d = S_BIN;
        end else if (in_valid_i && status_i.sync_find) begin
          cmd_o.find_start = 1'b1;
          state_d = S_LREQ;
        end
      end
      S_BIN: begin
        cmd_o.bin_step = 1'b1;
        if (status_i.bin_last) begin
          state_d = S_IDLE;
        end
      end
      S_LREQ: begin
        if (status_i.at_left_end) begin
          cmd_o.left_done = 1'b1;
          state_d = S_RREQ;
        end else begin
          cmd_o.rd_left = 1'b1;
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        if (status_i.bin_bit) begin
          cmd_o.left_step = 1'b1;
          state_d = S_LREQ;
        end else begin
          cmd_o.left_done = 1'b1;
          state_d = S_RREQ;
        end
      end
      S_RREQ: begin
        if (status_i.at_right_end) begin
          cmd_o.right_done = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_right = 1'b1;
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (status_i.bin_bit) begin
          cmd_o.right_step = 1'b1;
          state_d = S_RREQ;
        end else begin
          cmd_o.right_done = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> src/crbet_dp.sv
// Datapath for the row binarizer and edge tracker: line counters, pixel and
// binary row memories, edge walkers and the result register. Uses crbet_pkg.
module crbet_dp import crbet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [1:0]        func_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic [PIX_W-1:0]  level_i,
  input  logic [EDGE_W-1:0] center_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [ROW_W-1:0]  row_index_o,
  output logic [EDGE_W-1:0] left_edge_o,
  output logic [EDGE_W-1:0] right_edge_o,
  output logic              last_row_o
);

  logic [LINE_W-1:0]    line_q;
  logic [PIX_CNT_W-1:0] pix_idx_q;
  logic [LINE_W-1:0]    line_next;
  logic                 row_ok_next;
  logic                 capture;

  logic [PIX_W-1:0] pix_mem [ROW_WIDTH];
  logic             bin_mem [ROW_WIDTH];
  logic [PIX_W-1:0] pix_rd_q;
  logic             bin_rd_q;

  logic [STEP_W-1:0] step_q;
  logic              raw_prev_q;
  logic              fill_prev_q;
  logic              raw_new;
  logic [COL_W-1:0]  bin_waddr;
  logic              bin_wval;
  logic              bin_we;
  logic              pix_re;

  logic [COL_W-1:0]  idx_q;
  logic [COL_W-1:0]  mid_q;
  logic [COL_W-1:0]  left_q;
  logic [COL_W-1:0]  right_q;
  logic [EDGE_W-1:0] prev_left_q;
  logic [EDGE_W-1:0] prev_right_q;
  logic [ROW_W-1:0]  row_q;
  logic              last_q;
  logic [EDGE_W-1:0] mid_raw;
  logic [8:0]        mid_ext;
  logic [COL_W-1:0]  mid_clamp;
  logic [COL_W-1:0]  bin_raddr;

  logic              out_valid_q;
  logic              out_free;

  // Counter update of a line sync: saturates at the top.
  assign line_next   = (line_q == LINE_MAX) ? line_q : line_q + LINE_W'(1);
  assign row_ok_next = (line_next[LINE_W-1:2] < ROW_W'(ROWS));

  assign status_o.sync_bin  = (func_i == FUNC_SYNC) && row_ok_next &&
                              (line_next[1:0] == PH_BINARIZE);
  assign status_o.sync_find = (func_i == FUNC_SYNC) && row_ok_next &&
                              (line_next[1:0] == PH_SEARCH);

  assign capture = cmd_i.accept && (func_i == FUNC_PIXEL) &&
                   (line_q[1:0] == PH_CAPTURE) &&
                   (line_q[LINE_W-1:2] < ROW_W'(ROWS)) &&
                   (pix_idx_q < PIX_CNT_W'(ROW_WIDTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= '0;
      pix_idx_q <= '0;
    end else if (cmd_i.accept) begin
      if (func_i == FUNC_FRAME) begin
        line_q    <= '0;
        pix_idx_q <= '0;
      end else if (func_i == FUNC_SYNC) begin
        line_q    <= line_next;
        pix_idx_q <= '0;
      end else if (capture) begin
        pix_idx_q <= pix_idx_q + PIX_CNT_W'(1);
      end
    end
  end

  // Pixel row memory: written by capture, read by the binarize sweep.
  assign pix_re = cmd_i.bin_step && (step_q < STEP_W'(ROW_WIDTH));

  always_ff @(posedge clk_i) begin
    if (capture) begin
      pix_mem[pix_idx_q[COL_W-1:0]] <= pixel_i;
    end
    if (pix_re) begin
      pix_rd_q <= pix_mem[step_q[COL_W-1:0]];
    end
  end

  // Binarize sweep. The thresholded bit of column s-1 arrives at step s, and
  // column s-2 is written with its gap fill once both neighbors are known.
  assign raw_new   = (pix_rd_q > level_i);
  assign bin_waddr = COL_W'(step_q - STEP_W'(2));
  assign bin_we    = cmd_i.bin_step && (step_q >= STEP_W'(2));
  assign bin_wval  = ((bin_waddr == '0) || (bin_waddr == COL_W'(ROW_WIDTH - 1))) ?
                     raw_prev_q : (raw_prev_q | (fill_prev_q & raw_new));

  assign status_o.bin_last = (step_q == STEP_W'(ROW_WIDTH + 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.bin_start) begin
      step_q <= '0;
    end else if (cmd_i.bin_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_step && (step_q != '0)) begin
      raw_prev_q <= raw_new;
    end
    if (bin_we) begin
      fill_prev_q <= bin_wval;
    end
  end

  // Binary row memory: one write port for the sweep, one read for the walks.
  assign bin_raddr = cmd_i.rd_left ? (idx_q - COL_W'(1)) : (idx_q + COL_W'(1));

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wval;
    end
    if (cmd_i.rd_left || cmd_i.rd_right) begin
      bin_rd_q <= bin_mem[bin_raddr];
    end
  end

  assign status_o.bin_bit      = bin_rd_q;
  assign status_o.at_left_end  = (idx_q == '0);
  assign status_o.at_right_end = (idx_q == COL_W'(ROW_WIDTH - 1));

  // Search start column, clamped into the interior of the row.
  assign mid_raw = (line_next[LINE_W-1:2] == '0) ? center_i :
                   EDGE_W'(({1'b0, prev_left_q} + {1'b0, prev_right_q}) >> 1);
  assign mid_ext = 9'(mid_raw);

  always_comb begin
    if (mid_ext < 9'd1) begin
      mid_clamp = COL_W'(1);
    end else if (mid_ext > 9'(ROW_WIDTH - 2)) begin
      mid_clamp = COL_W'(ROW_WIDTH - 2);
    end else begin
      mid_clamp = COL_W'(mid_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find_start) begin
      mid_q <= mid_clamp;
      idx_q <= mid_clamp - COL_W'(1);
      row_q <= line_next[LINE_W-1:2];
      last_q <= (line_next == LAST_LINE);
    end else if (cmd_i.left_step) begin
      idx_q <= idx_q - COL_W'(1);
    end else if (cmd_i.left_done) begin
      left_q <= idx_q;
      idx_q  <= mid_q + COL_W'(1);
    end else if (cmd_i.right_step) begin
      idx_q <= idx_q + COL_W'(1);
    end else if (cmd_i.right_done) begin
      right_q <= idx_q;
    end
  end

  // Result register and the edges that seed the next row's search.
  assign out_free          = !out_valid_q || !out_stall_i;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q  <= 1'b1;
        prev_left_q  <= EDGE_W'(left_q);
        prev_right_q <= EDGE_W'(right_q);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      row_index_o  <= row_q;
      left_edge_o  <= EDGE_W'(left_q);
      right_edge_o <= EDGE_W'(right_q);
      last_row_o   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/camera_row_binarize_edge_track_core.sv
// Line-camera row binarizer and edge tracker, top level. Frame starts, pixels
// and plain syncs pass without holding the input; a binarize sync holds the
// input for a sweep of one pixel memory read per column; a search sync walks the
// binary row memory with a request state and a check state per column, plus
// any wait for a stalled result to leave the output register.
// Reset (rst_ni low, asynchronous) clears the counters, edges and output valid.
module camera_row_binarize_edge_track_core import crbet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input words from the camera stream.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [PIX_W-1:0]  pixel_i,
  // Result words, one per search sync.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROW_W-1:0]  row_index_o,
  output logic [EDGE_W-1:0] left_edge_o,
  output logic [EDGE_W-1:0] right_edge_o,
  output logic              last_row_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // The block accepts a word only while the controller sits idle. Pixels and
  // syncs that need no row work go through without a stall. The sync that ends a
  // capture line starts a sweep that thresholds each stored pixel and fills
  // single-column gaps; the sync after it walks left and then right from the
  // start column through the binary row and loads the result register. A
  // pending result does not block the input: only the final load waits for
  // the output register to empty.

  logic [PIX_W-1:0]  level_q;
  logic [EDGE_W-1:0] center_q;
  logic              reg_sel;
  logic              busy;
  cmd_t              cmd;
  status_t           status;

  // Register file. Writes land at the access phase.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LEVEL_RST;
      center_q <= CENTER_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_BINARY_LEVEL: level_q  <= pwdata[PIX_W-1:0];
        REG_FIRST_CENTER: center_q <= pwdata[EDGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BINARY_LEVEL: prdata = 32'(level_q);
      REG_FIRST_CENTER: prdata = 32'(center_q);
      default:          prdata = '0;
    endcase
  end

  crbet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  crbet_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .pixel_i      (pixel_i),
    .level_i      (level_q),
    .center_i     (center_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .row_index_o  (row_index_o),
    .left_edge_o  (left_edge_o),
    .right_edge_o (right_edge_o),
    .last_row_o   (last_row_o)
  );

  assign in_stall_o = busy;

  // The left edge lies left of the start column and the right edge right of it.
  a_edges_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_edge_o < right_edge_o))
    else $error("left edge not below right edge");

  // Edges stay inside the row.
  a_edges_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (right_edge_o <= EDGE_W'(ROW_WIDTH - 1)))
    else $error("right edge beyond row");

  // A new result only comes out of a search, during which input is held off.
  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a search");

endmodule

>>> sim/tb_top.sv
// Self-checking bench for camera_row_binarize_edge_track_core: camera words in, edge words out.
// Depends on crbet_pkg and the core. An in-bench model of the row binarizer
// and edge search predicts every edge word, and the monitor checks each one.
module tb_top;
  import crbet_pkg::*;

  // The fourth selector value has no meaning. The block must ignore it.
  localparam logic [1:0] FUNC_IDLE = 2'd3;

  // Drain time after the last expected word. This leaves ample margin for
  // a search sync to walk the binary row.
  localparam int DRAIN       = 400;
  localparam int LIMIT       = 1_000_000;
  localparam int PHASE_WORDS = 60;
  // The receiver holds off once, for a long stretch, after this many edge words.
  localparam int HOLD_AT     = 25;
  localparam int HOLD_LEN    = 600;

  typedef struct {
    logic [1:0]       func;
    logic [PIX_W-1:0] pixel;
  } cam_word_t;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] right;
    logic              last;
  } edge_word_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [1:0]        func_i       = '0;
  logic [PIX_W-1:0]  pixel_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [ROW_W-1:0]  row_index_o;
  logic [EDGE_W-1:0] left_edge_o;
  logic [EDGE_W-1:0] right_edge_o;
  logic              last_row_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [2:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  camera_row_binarize_edge_track_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .pixel_i      (pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_o  (row_index_o),
    .left_edge_o  (left_edge_o),
    .right_edge_o (right_edge_o),
    .last_row_o   (last_row_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Camera words still to be offered, and edge words still owed by the block.
  cam_word_t  cam_q[$];
  edge_word_t edges_q[$];

  int n_gen   = 0;  // words queued, not counting the ignored selector
  int n_taken = 0;  // camera words accepted by the block
  int n_edges = 0;  // edge words accepted from the block
  int n_err   = 0;
  int n_cyc   = 0;

  // Model state: a copy of the block's counters, row memories, last edges
  // and configuration. The row memories start at zero, but the stimulus
  // fills every column before the first binarize sync anyway.
  logic [LINE_W-1:0] m_line    = '0;
  int                m_pix     = 0;
  logic [PIX_W-1:0]  m_row_pix [ROW_WIDTH] = '{default: '0};
  bit                m_row_bin [ROW_WIDTH] = '{default: 1'b0};
  logic [EDGE_W-1:0] m_left    = '0;
  logic [EDGE_W-1:0] m_right   = '0;
  logic [PIX_W-1:0]  cfg_level  = LEVEL_RST;
  logic [EDGE_W-1:0] cfg_center = CENTER_RST;

  task automatic flag_miss(string what, int got, int want);
    n_err++;
    $display("mismatch %s: got %0d, want %0d", what, got, want);
  endtask

  // Advances the model by one accepted camera word. A sync that ends a row
  // (the second sync after the capture line) queues the expected edge word.
  function automatic void track_word(logic [1:0] f, logic [PIX_W-1:0] p);
    int         row;
    int         mid;
    int         i;
    edge_word_t w;
    if (f == FUNC_FRAME) begin
      m_line = '0;
      m_pix  = 0;
    end else if (f == FUNC_PIXEL) begin
      // Pixels land only on capture lines of rows in range, up to a full row.
      if (m_line[1:0] == PH_CAPTURE && (m_line >> 2) < ROWS && m_pix < ROW_WIDTH) begin
        m_row_pix[m_pix] = p;
        m_pix++;
      end
    end else if (f == FUNC_SYNC) begin
      // The line counter saturates rather than wrapping into a new frame.
      if (m_line != LINE_MAX) m_line++;
      m_pix = 0;
      row   = m_line >> 2;
      if (row < ROWS && m_line[1:0] == PH_BINARIZE) begin
        for (i = 0; i < ROW_WIDTH; i++) m_row_bin[i] = (m_row_pix[i] > cfg_level);
        // Gap fill runs in place, so a filled column feeds the next test.
        for (i = 1; i < ROW_WIDTH - 1; i++) begin
          if (m_row_bin[i-1] && m_row_bin[i+1]) m_row_bin[i] = 1'b1;
        end
      end else if (row < ROWS && m_line[1:0] == PH_SEARCH) begin
        mid = (row == 0) ? int'(cfg_center) : (int'(m_left) + int'(m_right)) >> 1;
        if (mid < 1) mid = 1;
        if (mid > ROW_WIDTH - 2) mid = ROW_WIDTH - 2;
        i = mid - 1;
        while (i > 0 && m_row_bin[i-1]) i--;
        m_left = EDGE_W'(i);
        i = mid + 1;
        while (i < ROW_WIDTH - 1 && m_row_bin[i+1]) i++;
        m_right = EDGE_W'(i);
        w.row   = ROW_W'(row);
        w.left  = m_left;
        w.right = m_right;
        w.last  = (m_line == LAST_LINE);
        edges_q.push_back(w);
      end
    end
  endfunction

  function automatic void put_word(logic [1:0] f, logic [PIX_W-1:0] p);
    cam_word_t c;
    c.func  = f;
    c.pixel = p;
    cam_q.push_back(c);
    if (f != FUNC_IDLE) n_gen++;
  endfunction

  // A gray value on the chosen side of the current binarize level.
  function automatic logic [PIX_W-1:0] shade(bit white);
    if (white && cfg_level != '1) return PIX_W'($urandom_range(255, int'(cfg_level) + 1));
    return PIX_W'($urandom_range(int'(cfg_level), 0));
  endfunction

  // One captured line: a white road band with speckle noise, so that the
  // gap fill and the outward search both see real work.
  function automatic void put_row(int n);
    int a;
    int b;
    int c;
    a = $urandom_range(ROW_WIDTH - 1, 0);
    b = $urandom_range(ROW_WIDTH - 1, a);
    for (c = 0; c < n; c++) begin
      if ($urandom_range(15, 0) == 0) put_word(FUNC_PIXEL, PIX_W'($urandom));
      else put_word(FUNC_PIXEL, shade((c >= a && c <= b) ^ ($urandom_range(9, 0) == 0)));
    end
  endfunction

  // Mostly short rows keep frames cheap. Full and overlong rows still come
  // often enough to refresh every column and to hit the surplus drop.
  function automatic int row_len();
    int k;
    k = $urandom_range(99, 0);
    if (k < 75) return $urandom_range(3, 0);
    if (k < 95) return $urandom_range(20, 4);
    if (k < 98) return ROW_WIDTH;
    return $urandom_range(ROW_WIDTH + 15, ROW_WIDTH + 1);
  endfunction

  // A well-formed frame: frame start, then four syncs per row with pixels on
  // the capture line and stray pixels elsewhere. Extra syncs run past the
  // last row and, when there are enough of them, into counter saturation.
  function automatic void put_frame(int rows, int extra);
    int r;
    int e;
    put_word(FUNC_FRAME, PIX_W'($urandom));
    for (r = 0; r < rows; r++) begin
      put_word(FUNC_SYNC, PIX_W'($urandom));
      put_row(row_len());
      put_word(FUNC_SYNC, PIX_W'($urandom));
      repeat ($urandom_range(2, 0)) put_word(FUNC_PIXEL, PIX_W'($urandom));
      put_word(FUNC_SYNC, PIX_W'($urandom));
      put_word(FUNC_SYNC, PIX_W'($urandom));
    end
    for (e = 0; e < extra; e++) begin
      put_word(FUNC_SYNC, PIX_W'($urandom));
      if ($urandom_range(3, 0) == 0) put_word(FUNC_PIXEL, PIX_W'($urandom));
    end
  endfunction

  // Waits until every queued word has been taken and every edge word has
  // come back, then lets a binarize or search still in flight finish.
  task automatic settle();
    while (cam_q.size() != 0 || in_valid_i || edges_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // The register takes the value at this edge. Start the read setup.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== v) flag_miss("register read back", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == REG_BINARY_LEVEL) cfg_level = PIX_W'(v);
    else cfg_center = EDGE_W'(v);
  endtask

  // One configuration phase: idle the block, set both registers, then queue
  // a mix of well-formed frames (most of it) and short bursts of noise.
  task automatic run_phase(logic [PIX_W-1:0] lvl, logic [EDGE_W-1:0] ctr, bit whole);
    int goal;
    int k;
    settle();
    write_reg(REG_BINARY_LEVEL, 32'(lvl));
    write_reg(REG_FIRST_CENTER, 32'(ctr));
    goal = n_gen + PHASE_WORDS;
    if (whole) put_frame(ROWS, $urandom_range(40, 20));
    while (n_gen < goal) begin
      k = $urandom_range(99, 0);
      if (k < 15) begin
        repeat ($urandom_range(8, 1)) put_word(2'($urandom_range(3, 0)), PIX_W'($urandom));
      end else if (k < 19) begin
        put_frame(ROWS, $urandom_range(40, 20));
      end else begin
        put_frame($urandom_range(10, 1), ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0);
      end
    end
  endtask

  // Driver. A word is taken at an edge where valid is high and stall low.
  // The model advances on that edge; then the next word is loaded, or
  // valid drops and the input sits idle. A stalled word stays put.
  cam_word_t nxt;
  bit        calm_in;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      track_word(func_i, pixel_i);
      n_taken++;
    end
    calm_in = (n_taken >= 600 && n_taken < 900);
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (cam_q.size() != 0 && (calm_in || $urandom_range(99, 0) >= 20)) begin
        nxt = cam_q.pop_front();
        in_valid_i <= 1'b1;
        func_i     <= nxt.func;
        pixel_i    <= nxt.pixel;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor. Each accepted edge word is checked field by field against the
  // oldest expected one. The stall is random with odds of about one in five,
  // quiet for a stretch, and held solid once so that the block backs up
  // and has to stall the camera side.
  edge_word_t want;
  int         hold_left = 0;
  bit         held      = 1'b0;
  bit         calm_out;

  // The long hold is counted in cycles here, apart from the monitor.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (n_edges == HOLD_AT && !held) begin
      held      <= 1'b1;
      hold_left <= HOLD_LEN;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (edges_q.size() == 0) begin
        flag_miss("edge word with none pending, row_index", row_index_o, -1);
      end else begin
        want = edges_q.pop_front();
        if (row_index_o !== want.row) flag_miss("row_index", row_index_o, want.row);
        if (left_edge_o !== want.left) flag_miss("left_edge", left_edge_o, want.left);
        if (right_edge_o !== want.right) flag_miss("right_edge", right_edge_o, want.right);
        if (last_row_o !== want.last) flag_miss("last_row", last_row_o, want.last);
      end
      n_edges++;
    end
    calm_out = (n_edges >= 60 && n_edges < 90);
    out_stall_i <= (hold_left != 0) || (!calm_out && $urandom_range(99, 0) < 20);
  end

  // Watchdog for a hang: a missing edge word or a stuck stall.
  always @(posedge clk_i) begin
    n_cyc++;
    if (n_cyc >= LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  int        c;
  logic [7:0] road;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening, at the reset register values. The ignored selector
    // and a pixel on an uncaptured line come first, then a sync with no
    // frame start, so the line count runs on from reset.
    put_word(FUNC_IDLE, 8'hFF);
    put_word(FUNC_PIXEL, 8'hAB);
    put_word(FUNC_SYNC, 8'h00);
    // A full row fills every column once. The road spans 20..60 with a lone
    // dark column at 25 (exactly at the level, so it reads dark and is
    // then filled) and a two-wide gap at 55..56 that stops the right search.
    for (c = 0; c < ROW_WIDTH; c++) begin
      if (c < 20 || c > 60 || c == 55 || c == 56) road = 8'h00;
      else if (c == 25) road = 8'd128;
      else if (c == 30) road = 8'd129;
      else road = 8'hFF;
      put_word(FUNC_PIXEL, road);
    end
    // Surplus pixels past the row width are dropped.
    put_word(FUNC_PIXEL, 8'hFF);
    put_word(FUNC_PIXEL, 8'h00);
    put_word(FUNC_SYNC, 8'hFF);   // binarize
    put_word(FUNC_SYNC, 8'h00);   // search row 0 from the first-row center
    put_word(FUNC_IDLE, 8'h00);
    put_word(FUNC_SYNC, 8'h00);
    put_word(FUNC_SYNC, 8'h00);   // capture line of row 1
    put_word(FUNC_PIXEL, 8'h00);  // short row: older columns stay
    put_word(FUNC_PIXEL, 8'hFF);
    put_word(FUNC_SYNC, 8'h00);
    put_word(FUNC_PIXEL, 8'hFF);  // binarize line, dropped
    put_word(FUNC_SYNC, 8'h00);   // search row 1 from the previous midpoint
    put_word(FUNC_FRAME, 8'h55);  // frame start in mid-frame
    put_word(FUNC_SYNC, 8'h00);
    put_word(FUNC_PIXEL, 8'd129);
    put_word(FUNC_PIXEL, 8'd128);
    put_word(FUNC_SYNC, 8'h00);
    put_word(FUNC_SYNC, 8'h00);   // row 0 again

    // Random phases. The first two take the register extremes. The next
    // two put the first-row center outside the legal columns, so that the
    // search start is clamped. The last is an ordinary setting.
    run_phase(8'd0, 7'd1, 1'b0);
    run_phase(8'd255, 7'd78, 1'b0);
    run_phase(PIX_W'($urandom), 7'd0, 1'b0);
    run_phase(PIX_W'($urandom), 7'd127, 1'b1);
    run_phase(PIX_W'($urandom), EDGE_W'($urandom_range(78, 1)), 1'b0);
    settle();

    if (n_err == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
